FILE: src/kss_pkg.sv
// Shared types and constants for the keyed slot store.
`timescale 1ns / 1ps

package kss_pkg;

    localparam int ENT_W     = 10;
    localparam int IN_DATA_W = 64;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 64;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_GET    = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MAP  = 2'd1,
        S_DEC  = 2'd2,
        S_GET  = 2'd3
    } state_t;

endpackage

FILE: src/kss_key_map.sv
// Key map memory: valid bit and slot per key, cleared by a sweep after reset.
`timescale 1ns / 1ps

module kss_key_map
    import kss_pkg::*;
#(
    parameter int KEYS  = 1024,
    parameter int SLOTS = 256
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(KEYS)-1:0]  rd_key,
    input  logic                     wr_en,
    input  logic [$clog2(KEYS)-1:0]  wr_key,
    input  logic                     wr_valid,
    input  logic [$clog2(SLOTS)-1:0] wr_slot,
    output logic                     ready,
    output logic                     rd_valid,
    output logic [$clog2(SLOTS)-1:0] rd_slot
);

    localparam int KW = $clog2(KEYS);
    localparam int SW = $clog2(SLOTS);

    logic [SW:0]   map_mem [KEYS];
    logic [SW:0]   rd_reg;
    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic [KW-1:0] clr_idx_reg;
    logic [KW-1:0] clr_idx_next;
    logic          mem_we;
    logic [KW-1:0] mem_waddr;
    logic [SW:0]   mem_wdata;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == KW'(KEYS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_key;
            mem_wdata = {wr_valid, wr_slot};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_reg <= map_mem[rd_key];
        end
    end

    assign ready    = !clr_busy_reg;
    assign rd_valid = rd_reg[SW];
    assign rd_slot  = rd_reg[SW-1:0];

endmodule

FILE: src/keyed_slot_store_with_free_list.sv
// Top level of the keyed slot store with a LIFO free list of slots.
`timescale 1ns / 1ps

// Each request beat (add, get, update, delete) yields one response beat.
// Every request reads the key map and the top of the free stack in S_MAP and
// decides and writes back in S_DEC; a get of a present key also reads the
// slot store there and answers from S_GET. The next request is taken in the
// cycle its predecessor hands its response to the output register. While an
// earlier response still waits there, the request in hand holds in S_DEC (or
// S_GET) and s_tready stays low until m_tready frees the register. After reset
// the key map is swept clear, during which s_tready stays low.
module keyed_slot_store_with_free_list
    import kss_pkg::*;
#(
    parameter int KEYS       = 1024,
    parameter int SLOTS      = 256,
    parameter int DATA_WIDTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // entity[9:0], component_data[73:10], zero pad
    input  logic [OP_W-1:0]      s_tuser,   // operation[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // read_data[63:0]
    output logic [STATUS_W-1:0]  m_tuser    // status[1:0]
);

    localparam int KW      = $clog2(KEYS);
    localparam int SW      = $clog2(SLOTS);
    localparam int CW      = $clog2(SLOTS + 1);
    localparam int MS      = ENT_W + KW;
    localparam int PW      = ENT_W + MS + 1;
    localparam int RECIP_I = ((1 << MS) + KEYS - 1) / KEYS;
    localparam int QW      = ENT_W + KW + 1;

    // request
    op_t                   op_reg;
    logic [ENT_W-1:0]      ent_reg;
    logic [ENT_W-1:0]      quo_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [PW-1:0]         quo_prod;
    logic [QW-1:0]         quo_keys;
    logic [QW-1:0]         key_diff;
    logic [KW-1:0]         key;

    // state
    state_t                state_reg;
    state_t                state_next;
    logic [CW-1:0]         fc_reg;
    logic [CW-1:0]         fc_next;
    logic [CW-1:0]         fc_dec;
    logic [CW-1:0]         hw_reg;
    logic [CW-1:0]         hw_next;

    // memories
    logic [DATA_WIDTH-1:0] slot_mem [SLOTS];
    logic [SW-1:0]         free_mem [SLOTS];
    logic [DATA_WIDTH-1:0] slot_rd_reg;
    logic [SW-1:0]         free_rd_reg;

    logic                  map_ready;
    logic                  map_rd_en;
    logic                  map_wr_en;
    logic                  map_wr_valid;
    logic [SW-1:0]         map_wr_slot;
    logic                  map_rd_valid;
    logic [SW-1:0]         map_rd_slot;
    logic                  fs_rd_en;
    logic                  fs_wr_en;
    logic                  slot_rd_en;
    logic                  slot_wr_en;
    logic [SW-1:0]         slot_wr_idx;

    // response
    logic                  m_tvalid_reg;
    status_t               status_reg;
    logic [M_TDATA_W-1:0]  rdata_reg;
    logic                  out_free;
    logic                  fin;
    status_t               res_status;
    logic                  res_get;
    logic                  accept;

    assign quo_prod = PW'(s_tdata[ENT_W-1:0]) * PW'(RECIP_I);
    assign quo_keys = QW'(quo_reg) * QW'(KEYS);
    assign key_diff = QW'(ent_reg) - quo_keys;
    assign key      = key_diff[KW-1:0];
    assign fc_dec   = fc_reg - 1'b1;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = map_ready && (state_reg == S_IDLE || fin);
    assign accept   = s_tvalid && s_tready;

    kss_key_map #(
        .KEYS  (KEYS),
        .SLOTS (SLOTS)
    ) u_key_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (map_rd_en),
        .rd_key   (key),
        .wr_en    (map_wr_en),
        .wr_key   (key),
        .wr_valid (map_wr_valid),
        .wr_slot  (map_wr_slot),
        .ready    (map_ready),
        .rd_valid (map_rd_valid),
        .rd_slot  (map_rd_slot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (op_reg == OP_GET && map_rd_valid)
                begin
                    state_next = S_GET;
                end
                else if (fin)
                begin
                    state_next = accept ? S_MAP : S_IDLE;
                end
            end
            S_GET:
            begin
                if (fin)
                begin
                    state_next = accept ? S_MAP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        map_rd_en    = 1'b0;
        map_wr_en    = 1'b0;
        map_wr_valid = 1'b0;
        map_wr_slot  = map_rd_slot;
        fs_rd_en     = 1'b0;
        fs_wr_en     = 1'b0;
        slot_rd_en   = 1'b0;
        slot_wr_en   = 1'b0;
        slot_wr_idx  = map_rd_slot;
        fin          = 1'b0;
        res_status   = ST_OK;
        res_get      = 1'b0;
        fc_next      = fc_reg;
        hw_next      = hw_reg;
        case (state_reg)
            S_IDLE:
            begin
            end
            S_MAP:
            begin
                map_rd_en = 1'b1;
                fs_rd_en  = 1'b1;
            end
            S_DEC:
            begin
                if (op_reg == OP_GET && map_rd_valid)
                begin
                    slot_rd_en = 1'b1;
                end
                else if (out_free)
                begin
                    fin = 1'b1;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (map_rd_valid)
                            begin
                                res_status = ST_PRESENT;
                            end
                            else if (fc_reg != '0)
                            begin
                                fc_next      = fc_dec;
                                map_wr_en    = 1'b1;
                                map_wr_valid = 1'b1;
                                map_wr_slot  = free_rd_reg;
                                slot_wr_en   = 1'b1;
                                slot_wr_idx  = free_rd_reg;
                            end
                            else if (hw_reg < CW'(SLOTS))
                            begin
                                hw_next      = hw_reg + 1'b1;
                                map_wr_en    = 1'b1;
                                map_wr_valid = 1'b1;
                                map_wr_slot  = hw_reg[SW-1:0];
                                slot_wr_en   = 1'b1;
                                slot_wr_idx  = hw_reg[SW-1:0];
                            end
                            else
                            begin
                                res_status = ST_FULL;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (map_rd_valid)
                            begin
                                slot_wr_en = 1'b1;
                            end
                            else
                            begin
                                res_status = ST_ABSENT;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (map_rd_valid)
                            begin
                                map_wr_en = 1'b1;
                                if (fc_reg < CW'(SLOTS))
                                begin
                                    fs_wr_en = 1'b1;
                                    fc_next  = fc_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                res_status = ST_ABSENT;
                            end
                        end
                        default:
                        begin
                            res_status = ST_ABSENT;
                        end
                    endcase
                end
            end
            S_GET:
            begin
                if (out_free)
                begin
                    fin     = 1'b1;
                    res_get = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fc_reg       <= '0;
            hw_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            hw_reg    <= hw_next;
            if (fin)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(s_tuser);
            ent_reg  <= s_tdata[ENT_W-1:0];
            quo_reg  <= quo_prod[MS +: ENT_W];
            data_reg <= s_tdata[ENT_W +: DATA_WIDTH];
        end
        if (fin)
        begin
            status_reg <= res_status;
            rdata_reg  <= res_get ? M_TDATA_W'(slot_rd_reg) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_wr_en)
        begin
            slot_mem[slot_wr_idx] <= data_reg;
        end
        if (slot_rd_en)
        begin
            slot_rd_reg <= slot_mem[map_rd_slot];
        end
        if (fs_wr_en)
        begin
            free_mem[fc_reg[SW-1:0]] <= map_rd_slot;
        end
        if (fs_rd_en)
        begin
            free_rd_reg <= free_mem[fc_dec[SW-1:0]];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rdata_reg;
    assign m_tuser  = status_reg;

    a_free_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= hw_reg)
        else $error("free count exceeds high-water mark");

    a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= CW'(SLOTS))
        else $error("high-water mark beyond slot count");

    a_no_work_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !map_ready |-> state_reg == S_IDLE)
        else $error("request in flight during key map clear");

    a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> m_tvalid_reg)
        else $error("finished request did not present a response");

endmodule
